@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL. Every check is sampled on the rising
// edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define FRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define FRT_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ src/frt_pkg.sv @@
package frt_pkg;

    localparam int FRT_MAX_FRAGMENTS = 1024;
    localparam int FRT_WORDS         = 4;
    localparam int FRT_WORD_W        = 64;
    localparam int FRT_CODE_W        = 16;
    localparam int FRT_INDEX_W       = 15;
    localparam int FRT_LAST_BIT      = 15;
    localparam int FRT_COUNT_W       = 11;
    localparam int FRT_STATUS_W      = 2;
    // Width of one presence-map row held in the row memory.
    localparam int FRT_ROW_BITS      = 128;
    localparam int FRT_ROW_SHIFT     = $clog2(FRT_ROW_BITS);

    localparam logic [FRT_STATUS_W-1:0] ST_ADDED  = 2'd0;
    localparam logic [FRT_STATUS_W-1:0] ST_DUP    = 2'd1;
    localparam logic [FRT_STATUS_W-1:0] ST_NEW    = 2'd2;
    localparam logic [FRT_STATUS_W-1:0] ST_REJECT = 2'd3;

    typedef struct packed {
        logic [FRT_WORDS-1:0][FRT_WORD_W-1:0] words;
        logic [FRT_CODE_W-1:0]                code;
    } frt_item_t;

    typedef struct packed {
        logic [FRT_COUNT_W-1:0]  expected_total;
        logic [FRT_COUNT_W-1:0]  arrived_count;
        logic                    complete;
        logic [FRT_STATUS_W-1:0] status;
    } frt_result_t;

endpackage

@@ src/frt_row_ram.sv @@
module frt_row_ram
    import frt_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int WIDTH = FRT_ROW_BITS
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read and a write in the same cycle return the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/frt_core.sv @@
module frt_core
    import frt_pkg::*;
#(
    parameter int MAX_FRAGMENTS = FRT_MAX_FRAGMENTS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [FRT_INDEX_W-1:0] rd_index,
    input  logic                   adv,
    input  frt_item_t              item,
    output frt_result_t            result
);

    localparam int ROWS   = (MAX_FRAGMENTS + FRT_ROW_BITS - 1) / FRT_ROW_BITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAGMENTS + 1);

    logic [FRT_WORDS-1:0][FRT_WORD_W-1:0] tmpl_words_reg;
    logic                                 tmpl_valid_reg;
    logic                                 tmpl_valid_next;
    logic                                 tmpl_load;
    logic [CNT_W-1:0]                     arrived_reg;
    logic [CNT_W-1:0]                     arrived_next;
    logic [CNT_W-1:0]                     known_reg;
    logic [CNT_W-1:0]                     known_next;
    logic [ROWS-1:0]                      row_valid_reg;
    logic [ROWS-1:0]                      row_valid_next;
    logic [ROW_AW-1:0]                    fwd_row_reg;
    logic [FRT_ROW_BITS-1:0]              fwd_data_reg;

    logic [FRT_INDEX_W-1:0]  idx;
    logic                    last;
    logic [ROW_AW-1:0]       row;
    logic [ROW_AW-1:0]       rd_row;
    logic [FRT_ROW_BITS-1:0] ram_data;
    logic [FRT_ROW_BITS-1:0] row_data;
    logic [FRT_ROW_BITS-1:0] onehot;
    logic [FRT_ROW_BITS-1:0] wr_data;
    logic                    wr_en;
    logic                    in_map;
    logic                    match;
    logic                    beyond;
    logic                    bit_set;
    logic [CNT_W-1:0]        idx_plus_one;
    logic [FRT_STATUS_W-1:0] status;

    assign idx    = item.code[FRT_INDEX_W-1:0];
    assign last   = item.code[FRT_LAST_BIT];
    assign row    = ROW_AW'(idx >> FRT_ROW_SHIFT);
    assign rd_row = ROW_AW'(rd_index >> FRT_ROW_SHIFT);
    assign onehot = FRT_ROW_BITS'(1) << idx[FRT_ROW_SHIFT-1:0];

    frt_row_ram #(
        .DEPTH (ROWS),
        .AW    (ROW_AW),
        .WIDTH (FRT_ROW_BITS)
    ) u_row_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_row),
        .rd_data (ram_data),
        .wr_en   (wr_en && adv),
        .wr_addr (row),
        .wr_data (wr_data)
    );

    // A row whose valid bit is clear belongs to an earlier packet and reads
    // as empty. The last written row is forwarded because the memory read
    // may have been issued in the same cycle as that write.
    always_comb
    begin
        if (!row_valid_reg[row])
        begin
            row_data = '0;
        end
        else if (fwd_row_reg == row)
        begin
            row_data = fwd_data_reg;
        end
        else
        begin
            row_data = ram_data;
        end
    end

    assign in_map       = {1'b0, idx} < 16'(MAX_FRAGMENTS);
    assign match        = tmpl_valid_reg && (tmpl_words_reg == item.words);
    assign beyond       = (known_reg != '0) && ({1'b0, idx} >= 16'(known_reg));
    assign bit_set      = |(row_data & onehot);
    assign idx_plus_one = CNT_W'(idx) + CNT_W'(1);

    always_comb
    begin
        status          = ST_REJECT;
        wr_en           = 1'b0;
        wr_data         = row_data | onehot;
        tmpl_valid_next = tmpl_valid_reg;
        tmpl_load       = 1'b0;
        arrived_next    = arrived_reg;
        known_next      = known_reg;
        row_valid_next  = row_valid_reg;
        if (!in_map)
        begin
            status = ST_REJECT;
        end
        else if (!match)
        begin
            // New packet: every row of the old packet is dropped at once.
            status              = ST_NEW;
            wr_en               = 1'b1;
            wr_data             = onehot;
            tmpl_valid_next     = 1'b1;
            tmpl_load           = 1'b1;
            row_valid_next      = '0;
            row_valid_next[row] = 1'b1;
            arrived_next        = CNT_W'(1);
            known_next          = last ? idx_plus_one : '0;
        end
        else if (beyond)
        begin
            status = ST_REJECT;
        end
        else
        begin
            if (bit_set)
            begin
                status = ST_DUP;
            end
            else
            begin
                status              = ST_ADDED;
                wr_en               = 1'b1;
                row_valid_next[row] = 1'b1;
                arrived_next        = arrived_reg + CNT_W'(1);
            end
            if (last)
            begin
                known_next = idx_plus_one;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmpl_valid_reg <= 1'b0;
            arrived_reg    <= '0;
            known_reg      <= '0;
            row_valid_reg  <= '0;
        end
        else if (adv)
        begin
            tmpl_valid_reg <= tmpl_valid_next;
            arrived_reg    <= arrived_next;
            known_reg      <= known_next;
            row_valid_reg  <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tmpl_load)
        begin
            tmpl_words_reg <= item.words;
        end
        if (adv && wr_en)
        begin
            fwd_row_reg  <= row;
            fwd_data_reg <= wr_data;
        end
    end

    assign result.status         = status;
    assign result.complete       = (known_next != '0) && (arrived_next == known_next);
    assign result.arrived_count  = FRT_COUNT_W'(arrived_next);
    assign result.expected_total = FRT_COUNT_W'(known_next);

endmodule

@@ src/fragment_reassembly_tracker.sv @@
// Fragment reassembly tracker. Each transfer on the slave side carries one
// fragment header: four 64-bit sequence words and a 16-bit fragment code whose
// top bit marks the last fragment and whose low 15 bits give the fragment
// index. A header whose words differ from the held template starts a new
// packet; a matching header marks its fragment in the presence map, and a
// repeated fragment is reported as a duplicate. Indexes at or above
// MAX_FRAGMENTS, or at or above the total fixed by a last fragment, are
// rejected without changing any state. Exactly one result transfer leaves the
// master side for every header taken, in order. The block takes one header
// per clock cycle when the master side keeps up. A header that is taken sits
// in the input stage, and its result is loaded into the result register and
// offered on the master side once that register is free or its transfer
// completes. This rate is set by the single read-modify-write of a
// presence-map row per header, with the row written by the previous header
// forwarded to the next one. The presence map lives in a memory of 128-bit
// rows with one valid flip-flop per row, so starting a new packet clears the
// map at once and no clearing pass is needed after reset.
`include "assert_macros.svh"

module fragment_reassembly_tracker
    import frt_pkg::*;
#(
    parameter int MAX_FRAGMENTS = FRT_MAX_FRAGMENTS
)
(
    input  logic         clk,
    input  logic         rst_n,
    // s_tdata fields from bit 0 up: old_state_number[63:0],
    // new_state_number[127:64], ack_number[191:128], discard_number[255:192],
    // fragment_code[271:256].
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [271:0] s_tdata,
    // m_tdata fields from bit 0 up: status[1:0], complete[2],
    // arrived_count[13:3], expected_total[24:14], zero fill[31:25].
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata
);

    localparam int CODE_LSB = FRT_WORDS * FRT_WORD_W;

    logic        accept;
    logic        adv;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    frt_item_t   item_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    frt_result_t res_reg;
    frt_result_t result;

    // The input stage moves on whenever the result register is free or its
    // transfer completes in this cycle, so a header is taken every cycle.
    assign adv      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || adv;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (adv)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.words[0] <= s_tdata[0*FRT_WORD_W +: FRT_WORD_W];
            item_reg.words[1] <= s_tdata[1*FRT_WORD_W +: FRT_WORD_W];
            item_reg.words[2] <= s_tdata[2*FRT_WORD_W +: FRT_WORD_W];
            item_reg.words[3] <= s_tdata[3*FRT_WORD_W +: FRT_WORD_W];
            item_reg.code     <= s_tdata[CODE_LSB +: FRT_CODE_W];
        end
        if (adv)
        begin
            res_reg <= result;
        end
    end

    // The presence-map row is read as the header is taken, so the row data
    // lines up with the header in the input stage.
    frt_core #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_index (s_tdata[CODE_LSB +: FRT_INDEX_W]),
        .adv      (adv),
        .item     (item_reg),
        .result   (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, res_reg.expected_total, res_reg.arrived_count,
                       res_reg.complete, res_reg.status};

    `FRT_ASSERT(a_new_packet_count, !m_valid_reg || res_reg.status != ST_NEW || res_reg.arrived_count == FRT_COUNT_W'(1), "new packet must report one fragment")
    `FRT_ASSERT(a_complete_counts, !m_valid_reg || !res_reg.complete || (res_reg.expected_total != '0 && res_reg.arrived_count == res_reg.expected_total), "complete flag disagrees with counts")
    `FRT_ASSERT_NEXT(a_stage_refills, s1_valid_reg && m_valid_reg && m_tready, m_valid_reg, "pending header did not reach result register")

endmodule

@@ bench/tb_fragment_reassembly_tracker.sv @@
`timescale 1ns / 100ps

// Testbench for the fragment reassembly tracker. A directed table covers
// rejects after reset, the first and last map index, duplicates, a last
// fragment seen again with a smaller index, a one-word template change and
// the largest possible total. Random packets follow: mostly shuffled,
// well-formed fragment runs with duplicates, out-of-range indexes and noise
// mixed in. An in-bench tracking model predicts every result not typed in.
module tb_fragment_reassembly_tracker;

    import frt_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 10;
    // Cycles with no transfer on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 140;

    typedef logic [FRT_WORDS-1:0][FRT_WORD_W-1:0] seq_words_t;

    // One row of the directed table. When typed_in is set, want holds the
    // result read straight off the rules; otherwise the tracking model decides.
    typedef struct {
        seq_words_t            words;
        logic [FRT_CODE_W-1:0] code;
        bit                    typed_in;
        frt_result_t           want;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [271:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;

    // Tracking model state, a private copy of what the block holds.
    bit                           tmpl_valid;
    seq_words_t                   tmpl_words;
    logic [FRT_MAX_FRAGMENTS-1:0] seen_map;
    int unsigned                  arrived_cnt;
    int unsigned                  known_total;

    frt_result_t reports_due[$];
    stim_row_t   directed_rows[$];
    seq_words_t  cur_template;

    int mismatch_count;
    int items_sent;
    int sender_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    fragment_reassembly_tracker u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // Builds a result from its four fields for the typed-in table rows.
    function automatic frt_result_t mk_result(input logic [FRT_STATUS_W-1:0] st,
                                              input logic done,
                                              input int unsigned arrived,
                                              input int unsigned total);
        frt_result_t r;
        r.status         = st;
        r.complete       = done;
        r.arrived_count  = arrived[FRT_COUNT_W-1:0];
        r.expected_total = total[FRT_COUNT_W-1:0];
        return r;
    endfunction

    // Applies one fragment header to the tracking model and returns the
    // result the block must report for it.
    function automatic frt_result_t track_fragment(input seq_words_t words,
                                                   input logic [FRT_CODE_W-1:0] code);
        logic                    is_last;
        int unsigned             idx;
        logic [FRT_STATUS_W-1:0] st;
        frt_result_t             r;
        is_last = code[FRT_LAST_BIT];
        idx     = 32'(code[FRT_INDEX_W-1:0]);
        if (idx >= FRT_MAX_FRAGMENTS) begin
            // Beyond the map: rejected whether or not the template matches.
            st = ST_REJECT;
        end
        else if (!(tmpl_valid && tmpl_words == words)) begin
            tmpl_valid    = 1'b1;
            tmpl_words    = words;
            seen_map      = '0;
            seen_map[idx] = 1'b1;
            arrived_cnt   = 1;
            known_total   = is_last ? idx + 1 : 0;
            st            = ST_NEW;
        end
        else if (known_total != 0 && idx >= known_total) begin
            st = ST_REJECT;
        end
        else begin
            if (seen_map[idx]) begin
                st = ST_DUP;
            end
            else begin
                seen_map[idx] = 1'b1;
                arrived_cnt++;
                st = ST_ADDED;
            end
            // A repeated or smaller last fragment still moves the total.
            if (is_last) begin
                known_total = idx + 1;
            end
        end
        r.status         = st;
        r.complete       = (known_total != 0 && arrived_cnt == known_total);
        r.arrived_count  = arrived_cnt[FRT_COUNT_W-1:0];
        r.expected_total = known_total[FRT_COUNT_W-1:0];
        return r;
    endfunction

    // Sequence words lean toward the extremes now and then.
    function automatic logic [FRT_WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offers one header on the slave side, idling first at the sender's
    // current rate, and records the expected result once the transfer is taken.
    task automatic send_fragment(input seq_words_t words,
                                 input logic [FRT_CODE_W-1:0] code,
                                 input bit typed_in,
                                 input frt_result_t want);
        frt_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {code, words};
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        // The model must advance even when the row's result is typed in.
        predicted = track_fragment(words, code);
        reports_due.push_back(typed_in ? want : predicted);
        items_sent++;
    endtask

    task automatic send_random(input seq_words_t words, input logic [FRT_CODE_W-1:0] code);
        send_fragment(words, code, 1'b0, '0);
    endtask

    // Holds the sender back until every outstanding result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reports_due.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // One random packet. Most are complete runs of fragments in shuffled order
    // with the last mark on the highest index; duplicates, out-of-range
    // indexes and stray headers are mixed in. The rest are sparse packets
    // spread over the whole map that usually never complete.
    task automatic run_packet();
        int                    order[64];
        int                    n;
        int                    j;
        int                    k;
        int                    tmp;
        int                    roll;
        int                    extra;
        logic [FRT_CODE_W-1:0] code;
        seq_words_t            noise;
        roll = $urandom_range(99);
        if ($urandom_range(4) == 0) begin
            // Same template except for a single bit of one word.
            k = $urandom_range(FRT_WORDS - 1);
            cur_template[k][$urandom_range(FRT_WORD_W - 1)] ^= 1'b1;
        end
        else begin
            for (k = 0; k < FRT_WORDS; k++) begin
                cur_template[k] = pick_word();
            end
        end
        if (roll < 85) begin
            n = (roll < 70) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            for (j = 0; j < n; j++) begin
                order[j] = j;
            end
            for (j = n - 1; j > 0; j--) begin
                k        = $urandom_range(j);
                tmp      = order[j];
                order[j] = order[k];
                order[k] = tmp;
            end
            for (j = 0; j < n; j++) begin
                code = {order[j] == n - 1, 15'(order[j])};
                send_random(cur_template, code);
                extra = $urandom_range(99);
                if (extra < 10) begin
                    k    = order[$urandom_range(j)];
                    code = {k == n - 1, 15'(k)};
                    send_random(cur_template, code);
                end
                else if (extra < 15) begin
                    code = {1'($urandom_range(1)), 15'($urandom_range(n, 32767))};
                    send_random(cur_template, code);
                end
                else if (extra < 18) begin
                    for (k = 0; k < FRT_WORDS; k++) begin
                        noise[k] = pick_word();
                    end
                    send_random(noise, 16'($urandom));
                end
            end
        end
        else begin
            n = $urandom_range(2, 6);
            for (j = 0; j < n; j++) begin
                send_random(cur_template, {1'b0, 15'($urandom_range(FRT_MAX_FRAGMENTS - 1))});
            end
            send_random(cur_template, {1'b1, 15'($urandom_range(FRT_MAX_FRAGMENTS - 1))});
            send_random(cur_template, {1'b0, 15'($urandom_range(FRT_MAX_FRAGMENTS - 1))});
        end
    endtask

    task automatic add_row(input seq_words_t words, input logic [FRT_CODE_W-1:0] code,
                           input bit typed_in, input frt_result_t want);
        stim_row_t row;
        row.words    = words;
        row.code     = code;
        row.typed_in = typed_in;
        row.want     = want;
        directed_rows.push_back(row);
    endtask

    // The receiver stalls at random at the current phase's rate.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result transfer is matched against the oldest expected result.
    always @(posedge clk) begin
        frt_result_t got;
        frt_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = frt_result_t'(m_tdata[24:0]);
            if (reports_due.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h", $time, got);
                mismatch_count++;
            end
            else begin
                want = reports_due.pop_front();
                if (got.status != want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    mismatch_count++;
                end
                if (got.complete != want.complete) begin
                    $display("%0t: complete expected %0d actual %0d",
                             $time, want.complete, got.complete);
                    mismatch_count++;
                end
                if (got.arrived_count != want.arrived_count) begin
                    $display("%0t: arrived_count expected %0d actual %0d",
                             $time, want.arrived_count, got.arrived_count);
                    mismatch_count++;
                end
                if (got.expected_total != want.expected_total) begin
                    $display("%0t: expected_total expected %0d actual %0d",
                             $time, want.expected_total, got.expected_total);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang detection: counts cycles in which neither side moves a transfer.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        seq_words_t w_zero;
        seq_words_t w_ones;
        seq_words_t w_alt;
        seq_words_t w_mix;
        int         i;
        int         phase;
        clk             = 1'b0;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        mismatch_count  = 0;
        items_sent      = 0;
        quiet_cycles    = 0;
        sender_idle_pct = 10;
        recv_stall_pct  = 10;
        tmpl_valid      = 1'b0;
        tmpl_words      = '0;
        seen_map        = '0;
        arrived_cnt     = 0;
        known_total     = 0;
        cur_template    = '0;

        w_zero    = '0;
        w_ones    = '1;
        w_alt     = w_ones;
        w_alt[2]  = w_alt[2] ^ 64'h1;
        w_mix     = {64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef,
                     64'hfedc_ba98_7654_3210, 64'h7fff_ffff_ffff_fffe};

        // Rejects right after reset: indexes beyond the map leave all state clear.
        add_row(w_ones, 16'h7FFF, 1'b1, mk_result(ST_REJECT, 1'b0, 0, 0));
        add_row(w_zero, 16'hFFFF, 1'b1, mk_result(ST_REJECT, 1'b0, 0, 0));
        add_row(w_zero, 16'h0400, 1'b1, mk_result(ST_REJECT, 1'b0, 0, 0));
        // An all-zero header still starts a packet, since no template is held yet.
        add_row(w_zero, 16'h0000, 1'b1, mk_result(ST_NEW, 1'b0, 1, 0));
        add_row(w_zero, 16'h0000, 1'b1, mk_result(ST_DUP, 1'b0, 1, 0));
        // Highest map index, then a last fragment below an index already held.
        add_row(w_zero, 16'h03FF, 1'b0, '0);
        add_row(w_zero, 16'h8001, 1'b0, '0);
        add_row(w_zero, 16'h0005, 1'b0, '0);
        add_row(w_zero, 16'h8001, 1'b0, '0);
        add_row(w_zero, 16'h8400, 1'b0, '0);
        // A single-fragment packet completes at once.
        add_row(w_ones, 16'h8000, 1'b1, mk_result(ST_NEW, 1'b1, 1, 1));
        add_row(w_ones, 16'h0000, 1'b0, '0);
        add_row(w_ones, 16'h0001, 1'b0, '0);
        // One bit of one word differs: a new packet, which then completes.
        add_row(w_alt, 16'h0002, 1'b0, '0);
        add_row(w_alt, 16'h0000, 1'b0, '0);
        add_row(w_alt, 16'h0001, 1'b0, '0);
        add_row(w_alt, 16'h8003, 1'b0, '0);
        // Last fragment seen again with a smaller index shrinks the total.
        add_row(w_alt, 16'h8001, 1'b0, '0);
        // A mismatching header with an index beyond the map changes nothing.
        add_row(w_mix, 16'h7C00, 1'b0, '0);
        // The largest total the map allows.
        add_row(w_mix, 16'h83FF, 1'b1, mk_result(ST_NEW, 1'b0, 1, FRT_MAX_FRAGMENTS));
        add_row(w_mix, 16'h0000, 1'b0, '0);
        add_row(w_mix, 16'h2AAA, 1'b0, '0);
        add_row(w_mix, 16'h5555, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            send_fragment(directed_rows[i].words, directed_rows[i].code,
                          directed_rows[i].typed_in, directed_rows[i].want);
        end
        // The sender waits here until the directed results have all arrived.
        drain_results();

        // Random phases: no idling, sender gaps, receiver stalls, then both.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin sender_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            i = items_sent + ITEMS_PER_PHASE;
            while (items_sent < i) begin
                run_packet();
            end
            drain_results();
        end

        // Any late or extra result transfer shows up during this short tail.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end
        else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
